@@ src/tbeq_pkg.sv @@
package tbeq_pkg;

  // Default widths of the sample path and the fixed-point formats.
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int POLE_FRAC_BITS_DEF = 8;
  localparam int COEF_FRAC_BITS_DEF = 16;

  // Configuration registers are 17-bit unsigned Q1.16 values.
  localparam int REG_W     = 17;
  localparam int CFG_IDX_W = 3;

  typedef logic [REG_W-1:0]     reg_val_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_LOW_COEF  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_HIGH_COEF = cfg_idx_t'(1);
  localparam cfg_idx_t REG_LOW_GAIN  = cfg_idx_t'(2);
  localparam cfg_idx_t REG_MID_GAIN  = cfg_idx_t'(3);
  localparam cfg_idx_t REG_HIGH_GAIN = cfg_idx_t'(4);

  localparam reg_val_t LOW_COEF_RST  = reg_val_t'(755);
  localparam reg_val_t HIGH_COEF_RST = reg_val_t'(4289);
  localparam reg_val_t GAIN_RST      = reg_val_t'(65536);

  // Pole state and filter structure.
  localparam int POLE_W  = 32;
  localparam int NSTAGES = 4;
  localparam int NHIST   = 3;

  // Multiply schedule: the two cascades interleave stage by stage, then the
  // three band gains follow. The last step only retires the final product.
  localparam int CASC_OPS    = 2 * NSTAGES;
  localparam int OP_LO_BAND  = CASC_OPS;
  localparam int OP_MID_BAND = CASC_OPS + 1;
  localparam int OP_HI_BAND  = CASC_OPS + 2;
  localparam int LAST_STEP   = CASC_OPS + 3;
  localparam int STEP_W      = $clog2(LAST_STEP + 1);

endpackage

@@ src/tbeq_if.sv @@
interface tbeq_in_if
  import tbeq_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface tbeq_out_if
  import tbeq_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface tbeq_cfg_if
  import tbeq_pkg::*;
;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  reg_val_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/three_band_equalizer_top.sv @@
// Channel | Dir | Payload                       | Beat when
// in_ch   | in  | sample_in, signed SAMPLE_BITS | valid && ready
// out_ch  | out | sample_out, signed, saturated | valid && ready
// cfg_ch  | in  | index 3 bits, data 17 bits    | valid && ready (ready is always high)
//
// A sample runs from its input beat until the next input beat can be taken
// through the steps of the single shared 33x18 multiplier (eight pole updates,
// three band gains and a final retire), a finish state that saturates and loads
// the output register and an idle state in which the next input beat is taken.
// A result waiting in the output register does not hold the input side back;
// only a second finished result waits for the first to leave.
// Reset is synchronous and active low; it clears the poles, the history and the
// control state and restores the register defaults.

module three_band_equalizer_top
  import tbeq_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int POLE_FRAC_BITS = POLE_FRAC_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tbeq_in_if.sink     in_ch,
  tbeq_out_if.source  out_ch,
  tbeq_cfg_if.sink    cfg_ch
);

  localparam int XW      = SAMPLE_BITS + POLE_FRAC_BITS;
  localparam int MUL_A_W = (XW + 1 > POLE_W + 1) ? XW + 1 : POLE_W + 1;
  localparam int MUL_B_W = REG_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int ACC_W   = PROD_W - COEF_FRAC_BITS + 2;

  localparam logic signed [MUL_A_W-1:0] XP_MAX =
    MUL_A_W'((64'd1 << (POLE_W - 1)) - 64'd1);
  localparam logic signed [MUL_A_W-1:0] XP_MIN = -XP_MAX - MUL_A_W'(1);
  localparam logic signed [SUM_W-1:0] UPD_MAX =
    SUM_W'((64'd1 << (POLE_W - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] UPD_MIN = -UPD_MAX - SUM_W'(1);
  localparam logic signed [ACC_W-1:0] Y_MAX =
    ACC_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  state_t                        state_r;
  logic [STEP_W-1:0]             step_r;
  reg_val_t                      low_coef_r, high_coef_r;
  reg_val_t                      low_gain_r, mid_gain_r, high_gain_r;
  logic signed [POLE_W-1:0]      lo_ring_r [NSTAGES];
  logic signed [POLE_W-1:0]      hi_ring_r [NSTAGES];
  logic signed [POLE_W-1:0]      lo_src_r, hi_src_r;
  logic signed [SAMPLE_BITS-1:0] hist_r [NHIST];
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [SAMPLE_BITS-1:0] out_data_r;
  logic                          out_valid_r;

  logic signed [XW-1:0]          x_shift;
  logic signed [MUL_A_W-1:0]     x_ext;
  logic signed [POLE_W-1:0]      xp;
  logic                          issue_sel;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]      prod_nxt;
  logic signed [PROD_W-1:0]      prod_sh;
  logic                          cons_sel;
  logic                          cons_casc;
  logic signed [POLE_W-1:0]      cons_pole;
  logic signed [SUM_W-1:0]       upd_sum;
  logic signed [POLE_W-1:0]      upd;
  logic signed [ACC_W-1:0]       y_shift;
  logic signed [SAMPLE_BITS-1:0] y;
  logic                          in_beat;
  logic                          out_free;
  logic                          out_load;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == ST_FINISH) && out_free;

  // Input sample in pole format, clamped to the 32-bit pole range.
  always_comb begin
    x_shift = XW'(in_ch.sample_in) <<< POLE_FRAC_BITS;
    x_ext   = MUL_A_W'(x_shift);
    if (x_ext > XP_MAX) begin
      xp = POLE_W'(XP_MAX);
    end else if (x_ext < XP_MIN) begin
      xp = POLE_W'(XP_MIN);
    end else begin
      xp = POLE_W'(x_ext);
    end
  end

  // Operand selection for the shared multiplier. Even steps serve the low
  // cascade and odd steps the high cascade; the head of each ring is always
  // the stage due next.
  always_comb begin
    issue_sel = step_r[0];
    mul_a     = '0;
    mul_b     = '0;
    case (step_r) inside
      [STEP_W'(0):STEP_W'(CASC_OPS - 1)]: begin
        mul_a = issue_sel ? (MUL_A_W'(hi_src_r) - MUL_A_W'(hi_ring_r[0]))
                          : (MUL_A_W'(lo_src_r) - MUL_A_W'(lo_ring_r[0]));
        mul_b = issue_sel ? MUL_B_W'(high_coef_r) : MUL_B_W'(low_coef_r);
      end
      STEP_W'(OP_LO_BAND): begin
        mul_a = MUL_A_W'(lo_ring_r[NSTAGES-1]);
        mul_b = MUL_B_W'(low_gain_r);
      end
      STEP_W'(OP_MID_BAND): begin
        mul_a = MUL_A_W'(hi_ring_r[NSTAGES-1]) - MUL_A_W'(lo_ring_r[NSTAGES-1]);
        mul_b = MUL_B_W'(mid_gain_r);
      end
      STEP_W'(OP_HI_BAND): begin
        mul_a = (MUL_A_W'(hist_r[NHIST-1]) <<< POLE_FRAC_BITS)
              - MUL_A_W'(hi_ring_r[NSTAGES-1]);
        mul_b = MUL_B_W'(high_gain_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign prod_sh  = prod_r >>> COEF_FRAC_BITS;

  // The product registered last cycle belongs to the previous step.
  always_comb begin
    cons_sel  = !step_r[0];
    cons_casc = (step_r <= STEP_W'(CASC_OPS));
    cons_pole = cons_sel ? hi_ring_r[0] : lo_ring_r[0];
    upd_sum   = SUM_W'(cons_pole) + SUM_W'(prod_sh);
    if (upd_sum > UPD_MAX) begin
      upd = POLE_W'(UPD_MAX);
    end else if (upd_sum < UPD_MIN) begin
      upd = POLE_W'(UPD_MIN);
    end else begin
      upd = POLE_W'(upd_sum);
    end
  end

  always_comb begin
    y_shift = acc_r >>> POLE_FRAC_BITS;
    if (y_shift > Y_MAX) begin
      y = SAMPLE_BITS'(Y_MAX);
    end else if (y_shift < Y_MIN) begin
      y = SAMPLE_BITS'(Y_MIN);
    end else begin
      y = SAMPLE_BITS'(y_shift);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      low_coef_r  <= LOW_COEF_RST;
      high_coef_r <= HIGH_COEF_RST;
      low_gain_r  <= GAIN_RST;
      mid_gain_r  <= GAIN_RST;
      high_gain_r <= GAIN_RST;
      lo_src_r    <= '0;
      hi_src_r    <= '0;
      for (int i = 0; i < NSTAGES; i++) begin
        lo_ring_r[i] <= '0;
        hi_ring_r[i] <= '0;
      end
      for (int i = 0; i < NHIST; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_LOW_COEF:  low_coef_r  <= cfg_ch.data;
          REG_HIGH_COEF: high_coef_r <= cfg_ch.data;
          REG_LOW_GAIN:  low_gain_r  <= cfg_ch.data;
          REG_MID_GAIN:  mid_gain_r  <= cfg_ch.data;
          REG_HIGH_GAIN: high_gain_r <= cfg_ch.data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            sample_r <= in_ch.sample_in;
            lo_src_r <= xp;
            hi_src_r <= xp;
            acc_r    <= '0;
            step_r   <= '0;
            state_r  <= ST_RUN;
          end
        end
        ST_RUN: begin
          prod_r <= prod_nxt;
          if (step_r != '0) begin
            if (cons_casc) begin
              // Retire the head stage: rotate the ring so that the updated
              // pole lands at the tail and feeds the next stage.
              if (cons_sel) begin
                for (int i = 0; i < NSTAGES - 1; i++) begin
                  hi_ring_r[i] <= hi_ring_r[i+1];
                end
                hi_ring_r[NSTAGES-1] <= upd;
                hi_src_r             <= upd;
              end else begin
                for (int i = 0; i < NSTAGES - 1; i++) begin
                  lo_ring_r[i] <= lo_ring_r[i+1];
                end
                lo_ring_r[NSTAGES-1] <= upd;
                lo_src_r             <= upd;
              end
            end else begin
              acc_r <= acc_r + ACC_W'(prod_sh);
            end
          end
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(LAST_STEP)) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_data_r  <= y;
            hist_r[0]   <= sample_r;
            for (int i = 1; i < NHIST; i++) begin
              hist_r[i] <= hist_r[i-1];
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("output beat raised without a finished sample");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (step_r <= STEP_W'(LAST_STEP)))
    else $error("sequencer step ran past the schedule");

  a_run_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && step_r == STEP_W'(LAST_STEP)) |=> (state_r == ST_FINISH))
    else $error("sequencer did not finish after the last step");

  a_acc_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && $past(state_r == ST_FINISH)) |-> $stable(acc_r))
    else $error("band sum changed while waiting for the output register");

  a_poles_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && $past(state_r == ST_IDLE))
      |-> ($stable(lo_ring_r[NSTAGES-1]) && $stable(hi_ring_r[NSTAGES-1])))
    else $error("pole state moved while idle");

endmodule
